@@ rtl/takf_pkg.sv @@
// takf_pkg: shared types, codes and helpers of the tilt angle kalman filter
`timescale 1ns / 1ps
package takf_pkg;

  localparam int COV_FRAC_BITS_DEF = 30;

  // register reset values in Q2.30
  localparam longint RST_DT = 64'd8589935;
  localparam longint RST_QA = 64'd1073742;
  localparam longint RST_QG = 64'd5368709;
  localparam longint RST_R  = 64'd536870912;
  localparam longint RST_C  = 64'd1073741824;

  // configuration register indexes
  localparam logic [2:0] CFG_DT = 3'd0;
  localparam logic [2:0] CFG_QA = 3'd1;
  localparam logic [2:0] CFG_QG = 3'd2;
  localparam logic [2:0] CFG_R  = 3'd3;
  localparam logic [2:0] CFG_C  = 3'd4;

  // one multiply and write-back each
  typedef enum logic [3:0] {
    OP_ANG  = 4'd0,
    OP_P00  = 4'd1,
    OP_P01  = 4'd2,
    OP_P11  = 4'd3,
    OP_PCT0 = 4'd4,
    OP_PCT1 = 4'd5,
    OP_E    = 4'd6,
    OP_T1   = 4'd7,
    OP_C00  = 4'd8,
    OP_C01  = 4'd9,
    OP_C10  = 4'd10,
    OP_C11  = 4'd11,
    OP_ANGC = 4'd12,
    OP_BIAS = 4'd13
  } op_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic wb;
    op_t  op;
    logic div_start;
    logic div_step;
    logic div_sel;
    logic k_clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic e_pos;
    logic div_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) res = 32'sh7fffffff;
    else if (v < -64'sd2147483648) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

endpackage

@@ rtl/takf_ctrl.sv @@
// takf_ctrl: sequencer of the filter step
`timescale 1ns / 1ps
module takf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  takf_pkg::status_t status,
  output takf_pkg::cmd_t    cmd
);
  import takf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_WB   = 6'b000100,
    ST_DIVS = 6'b001000,
    ST_DIVR = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   sel, sel_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    op_next       = op;
    sel_next      = sel;
    cmd           = '0;
    cmd.op        = op;
    cmd.div_sel   = sel;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          op_next    = OP_ANG;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.issue  = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (op == OP_T1) begin
          if (status.e_pos) begin
            sel_next   = 1'b0;
            state_next = ST_DIVS;
          end else begin
            cmd.k_clear = 1'b1;
            op_next     = OP_C00;
            state_next  = ST_MUL;
          end
        end else if (op == OP_BIAS) begin
          state_next = ST_FIN;
        end else begin
          op_next    = op_t'(4'(op) + 4'd1);
          state_next = ST_MUL;
        end
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVR;
      end
      ST_DIVR: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          if (!sel) begin
            sel_next   = 1'b1;
            state_next = ST_DIVS;
          end else begin
            op_next    = OP_C00;
            state_next = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_ANG;
      sel      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      sel   <= sel_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/takf_dp.sv @@
// takf_dp: registers, multiplier, divider and state of the filter
`timescale 1ns / 1ps
module takf_dp #(
  parameter int COV_FRAC_BITS = takf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  takf_pkg::cmd_t    cmd,
  output takf_pkg::status_t status,
  input  logic [63:0]       in_data,
  output logic [63:0]       out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  import takf_pkg::*;

  localparam int SH    = 30 - COV_FRAC_BITS;
  localparam int NUMW  = 32 + COV_FRAC_BITS;
  localparam int CNTW  = $clog2(NUMW + 1);
  localparam int DW    = 35;

  // configuration registers
  logic [29:0] dt, qa, qg;
  logic [30:0] rn, cg;

  // filter state and step temporaries
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] am, gm, rate_c, pct0, pct1, t1, k0, k1;
  logic signed [32:0] err;
  logic signed [34:0] e;

  // multiplier
  logic signed [63:0] mul_a, mul_b, a_abs, b_abs, r;
  logic [65:0] prod, rnd, rmag;
  logic        neg;

  // divider
  logic [NUMW-1:0] dq, q_fin;
  logic [DW-1:0]   rem, rem_sh;
  logic [CNTW-1:0] cnt;
  logic            dneg, ge;
  logic [31:0]     nmag;
  logic signed [31:0] num;
  logic signed [63:0] qs;

  logic signed [31:0] out_angle, out_rate;

  assign status.e_pos    = !e[34] && (e != '0);
  assign status.div_done = (cnt == CNTW'(1));
  assign out_data        = {out_rate, out_angle};

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= 30'(RST_DT >> SH);
      qa <= 30'(RST_QA >> SH);
      qg <= 30'(RST_QG >> SH);
      rn <= 31'(RST_R >> SH);
      cg <= 31'(RST_C >> SH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DT: dt <= cfg_data[29:0];
        CFG_QA: qa <= cfg_data[29:0];
        CFG_QG: qg <= cfg_data[29:0];
        CFG_R:  rn <= cfg_data;
        CFG_C:  cg <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection
  always_comb begin
    case (cmd.op)
      OP_ANG:  begin mul_a = 64'(rate_c); mul_b = 64'(dt); end
      OP_P00:  begin mul_a = 64'(qa) - 64'(p01) - 64'(p10); mul_b = 64'(dt); end
      OP_P01:  begin mul_a = 64'(p11); mul_b = 64'(dt); end
      OP_P11:  begin mul_a = 64'(qg); mul_b = 64'(dt); end
      OP_PCT0: begin mul_a = 64'(cg); mul_b = 64'(p00); end
      OP_PCT1: begin mul_a = 64'(cg); mul_b = 64'(p10); end
      OP_E:    begin mul_a = 64'(cg); mul_b = 64'(pct0); end
      OP_T1:   begin mul_a = 64'(cg); mul_b = 64'(p01); end
      OP_C00:  begin mul_a = 64'(k0); mul_b = 64'(pct0); end
      OP_C01:  begin mul_a = 64'(k0); mul_b = 64'(t1); end
      OP_C10:  begin mul_a = 64'(k1); mul_b = 64'(pct0); end
      OP_C11:  begin mul_a = 64'(k1); mul_b = 64'(t1); end
      OP_ANGC: begin mul_a = 64'(k0); mul_b = 64'(err); end
      default: begin mul_a = 64'(k1); mul_b = 64'(err); end
    endcase
    a_abs = mul_a[63] ? -mul_a : mul_a;
    b_abs = mul_b[63] ? -mul_b : mul_b;
  end

  // rounding half away from zero
  always_comb begin
    rnd  = prod + (66'(1) << (COV_FRAC_BITS - 1));
    rmag = rnd >> COV_FRAC_BITS;
    r    = neg ? -(64'(rmag)) : 64'(rmag);
  end

  // divider step and final quotient
  always_comb begin
    num    = cmd.div_sel ? pct1 : pct0;
    nmag   = num[31] ? 32'(-num) : 32'(num);
    rem_sh = {rem[DW-2:0], dq[NUMW-1]};
    ge     = (rem_sh >= DW'(e));
    q_fin  = {dq[NUMW-2:0], ge};
    qs     = dneg ? -(64'(q_fin)) : 64'(q_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      p00  <= 32'sd1 <<< COV_FRAC_BITS;
      p01  <= '0;
      p10  <= '0;
      p11  <= 32'sd1 <<< COV_FRAC_BITS;
      cnt  <= '0;
    end else begin
      if (cmd.load) begin
        am     <= in_data[31:0];
        gm     <= in_data[63:32];
        rate_c <= sat32(64'($signed(in_data[63:32])) - 64'(bias));
      end
      if (cmd.issue) begin
        prod <= a_abs[32:0] * b_abs[32:0];
        neg  <= mul_a[63] ^ mul_b[63];
        if (cmd.op == OP_P00) err <= 33'(am) - 33'(ang);
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_ANG:  ang  <= sat32(64'(ang) + r);
          OP_P00:  p00  <= sat32(64'(p00) + r);
          OP_P01: begin
            p01 <= sat32(64'(p01) - r);
            p10 <= sat32(64'(p10) - r);
          end
          OP_P11:  p11  <= sat32(64'(p11) + r);
          OP_PCT0: pct0 <= sat32(r);
          OP_PCT1: pct1 <= sat32(r);
          OP_E:    e    <= 35'(64'(rn) + r);
          OP_T1:   t1   <= sat32(r);
          OP_C00:  p00  <= sat32(64'(p00) - r);
          OP_C01:  p01  <= sat32(64'(p01) - r);
          OP_C10:  p10  <= sat32(64'(p10) - r);
          OP_C11:  p11  <= sat32(64'(p11) - r);
          OP_ANGC: ang  <= sat32(64'(ang) + r);
          default: bias <= sat32(64'(bias) + r);
        endcase
      end
      if (cmd.k_clear) begin
        k0 <= '0;
        k1 <= '0;
      end
      if (cmd.div_start) begin
        dq   <= NUMW'(nmag) << COV_FRAC_BITS;
        dneg <= num[31];
        rem  <= '0;
        cnt  <= CNTW'(NUMW);
      end else if (cmd.div_step) begin
        rem <= ge ? rem_sh - DW'(e) : rem_sh;
        dq  <= q_fin;
        cnt <= cnt - CNTW'(1);
        if (status.div_done) begin
          if (cmd.div_sel) k1 <= sat32(qs);
          else k0 <= sat32(qs);
        end
      end
      if (cmd.out_load) begin
        out_angle <= ang;
        out_rate  <= sat32(64'(gm) - 64'(bias));
      end
    end
  end

endmodule

@@ rtl/tilt_angle_kalman_filter.sv @@
// tilt_angle_kalman_filter: top level of the two-state angle and gyro bias kalman filter
`timescale 1ns / 1ps
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: measured_angle, measured_rate
//  m_*      | out | m_tvalid/m_tready  | m_tdata: filtered_angle, filtered_rate
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one item at a time: 14 multiply/write-back pairs, two restoring divisions
//  of 32+COV_FRAC_BITS quotient bits with one start step each, one load and
//  one finish step; the divisions are skipped when the innovation is not
//  positive, and the gains are then zero
//  the gain divider is bit-serial; the default covariance format is Q2.30
//  reset is synchronous; covariance returns to identity, estimates to zero
//  a result waiting on m_tready does not hold off the next transaction on s_*
//
module tilt_angle_kalman_filter #(
  parameter int COV_FRAC_BITS = takf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] measured_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] filtered_angle, [63:32] filtered_rate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import takf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  takf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  takf_dp #(
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a step was running");

  // a finished step presents its result
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result not presented after finish");

  // gain division only with a positive innovation variance
  a_div_guard: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> status.e_pos)
    else $error("division started with non-positive divisor");

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench of the tilt angle kalman filter
`timescale 1ns / 1ps
module tb;
  import takf_pkg::*;

  localparam int CFB = 30;
  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  always #4 clk = ~clk;

  tilt_angle_kalman_filter #(.COV_FRAC_BITS(CFB)) i_dut (.*);

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } est_t;

  // predictor state and registers
  longint dt_r, qa_r, qg_r, r_r, c_r;
  longint ang_est, bias_est;
  longint pcov[4];
  est_t   est_q[$];

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  n_cfg = 0;
  bit  idle_en = 1'b1;
  int  hold_req_n = 0;
  int  hold_seen = 0;
  int  hold_cycles = 0;
  int  wdog = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product shifted down by the covariance fraction, rounded half away from zero
  function automatic longint fxmul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, m, r;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    m = ua * ub;
    r = (m + (64'd1 << (CFB - 1))) >> CFB;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void predictor_reset();
    dt_r = RST_DT; qa_r = RST_QA; qg_r = RST_QG; r_r = RST_R; c_r = RST_C;
    ang_est = 0; bias_est = 0;
    pcov[0] = 64'sd1 << CFB; pcov[1] = 0; pcov[2] = 0; pcov[3] = 64'sd1 << CFB;
  endfunction

  function automatic void predict_step(logic [31:0] am_in, logic [31:0] gm_in);
    longint am, gm, p00, p01, p10, p11, rc, err, pct0, pct1, t1, e, k0, k1;
    est_t   x;
    am = longint'($signed(am_in));
    gm = longint'($signed(gm_in));
    p00 = pcov[0]; p01 = pcov[1]; p10 = pcov[2]; p11 = pcov[3];
    k0 = 0; k1 = 0;
    rc = clip32(gm - bias_est);
    ang_est = clip32(ang_est + fxmul(rc, dt_r));
    err = am - ang_est;
    p00 = clip32(p00 + fxmul(qa_r - p01 - p10, dt_r));
    p01 = clip32(p01 - fxmul(p11, dt_r));
    p10 = clip32(p10 - fxmul(p11, dt_r));
    p11 = clip32(p11 + fxmul(qg_r, dt_r));
    pct0 = clip32(fxmul(c_r, p00));
    pct1 = clip32(fxmul(c_r, p10));
    e = r_r + fxmul(c_r, pct0);
    // non-positive innovation leaves gains at zero
    if (e > 0) begin
      k0 = clip32((pct0 * (64'sd1 << CFB)) / e);
      k1 = clip32((pct1 * (64'sd1 << CFB)) / e);
    end
    t1 = clip32(fxmul(c_r, p01));
    pcov[0] = clip32(p00 - fxmul(k0, pct0));
    pcov[1] = clip32(p01 - fxmul(k0, t1));
    pcov[2] = clip32(p10 - fxmul(k1, pct0));
    pcov[3] = clip32(p11 - fxmul(k1, t1));
    ang_est = clip32(ang_est + fxmul(k0, err));
    bias_est = clip32(bias_est + fxmul(k1, err));
    x.angle = ang_est[31:0];
    x.rate = 32'(clip32(gm - bias_est));
    est_q.push_back(x);
  endfunction

  // sender gap before one sample in four on average, while idle_en is set
  task automatic maybe_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // tvalid stays up until a gap or a drain takes it down
  task automatic send_sample(logic [31:0] am, logic [31:0] gm);
    maybe_gap();
    s_tvalid <= 1'b1;
    s_tdata <= {gm, am};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_step(am, gm);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // cfg_valid stays up until the caller takes it down
  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    case (idx)
      CFG_DT: dt_r = longint'(val & 31'h3fffffff);
      CFG_QA: qa_r = longint'(val & 31'h3fffffff);
      CFG_QG: qg_r = longint'(val & 31'h3fffffff);
      CFG_R:  r_r = longint'(val);
      CFG_C:  c_r = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_all(logic [30:0] dt, logic [30:0] qa, logic [30:0] qg,
                         logic [30:0] r, logic [30:0] c);
    drain();
    write_reg(CFG_DT, dt);
    write_reg(CFG_QA, qa);
    write_reg(CFG_QG, qg);
    write_reg(CFG_R, r);
    write_reg(CFG_C, c);
    cfg_valid <= 1'b0;
  endtask

  // uniform value from -span to +span, for small angles and gyro rates
  function automatic logic [31:0] near_val(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic test_directed();
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    send_sample(32'h0, 32'h0);
    foreach (ext[i])
      foreach (ext[j]) send_sample(ext[i], ext[j]);
    send_sample(32'h00010000, 32'h00008000);
    send_sample(32'hffff0000, 32'h55555555);
    send_sample(32'haaaaaaaa, 32'h00000001);
  endtask

  task automatic test_register_extremes();
    // zero interval, zero noise, zero observation, r of one LSB: smallest positive innovation
    set_all(31'd0, 31'd0, 31'd0, 31'd1, 31'd0);
    repeat (6) send_sample($urandom, $urandom);
    set_all(31'h3fffffff, 31'h3fffffff, 31'h3fffffff, 31'h7fffffff, 31'h7fffffff);
    repeat (8) send_sample($urandom, $urandom);
    set_all(31'd1, 31'd0, 31'd0, 31'd1, 31'h40000000);
    repeat (6) send_sample(near_val(1 << 20), near_val(1 << 18));
    // out-of-range index is ignored
    drain();
    write_reg(3'd5, 31'h7fffffff);
    write_reg(3'd7, 31'h0);
    cfg_valid <= 1'b0;
    repeat (4) send_sample(near_val(1 << 20), near_val(1 << 18));
  endtask

  task automatic test_random(int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (k % 250 == 0) begin
        if ($urandom_range(0, 1))
          set_all(31'(RST_DT), 31'(RST_QA), 31'(RST_QG), 31'(RST_R), 31'(RST_C));
        else
          set_all(31'($urandom_range(1, 31'h3fffffff) >> $urandom_range(0, 12)),
                  31'($urandom & 31'h3fffffff >> $urandom_range(0, 14)),
                  31'($urandom & 31'h3fffffff >> $urandom_range(0, 14)),
                  31'($urandom_range(1, 31'h7fffffff) >> $urandom_range(0, 8)),
                  31'((31'h40000000 >> $urandom_range(0, 2)) + near_val(1 << 24)));
      end
      if ($urandom_range(0, 9) == 0) send_sample($urandom, $urandom);
      else send_sample(near_val(90 << 16), near_val(200 << 16));
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    hold_req_n++;
    repeat (6) send_sample(near_val(1 << 22), near_val(1 << 20));
    // sender waits for every estimate to come back
    drain();
    repeat (4) send_sample(near_val(1 << 22), near_val(1 << 20));
  endtask

  // receiver side: random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_seen != hold_req_n) begin
      hold_seen <= hold_req_n;
      hold_cycles <= 600;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (idle_en) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    est_t x;
    if (!rst && m_tvalid && m_tready) begin
      n_recv++;
      if (est_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        n_fail++;
      end else begin
        x = est_q.pop_front();
        if (m_tdata[31:0] !== x.angle) begin
          $error("filtered_angle expected %h got %h", x.angle, m_tdata[31:0]);
          n_fail++;
        end
        if (m_tdata[63:32] !== x.rate) begin
          $error("filtered_rate expected %h got %h", x.rate, m_tdata[63:32]);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
        || rst || hold_cycles > 0)
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    predictor_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(1500);
    idle_en = 1'b0;
    test_random(200);
    drain();
    $display("covered %0d samples, %0d estimates, %0d register writes", n_sent, n_recv, n_cfg);
    if (n_fail == 0 && est_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/takf_pkg.sv
rtl/takf_ctrl.sv
rtl/takf_dp.sv
rtl/tilt_angle_kalman_filter.sv
verif/tb.sv
